@@ sv/stx_etx_xor_frame_receiver_defines.svh @@
// Assertion macros for the framed byte receiver.
// Included by the RTL files that carry concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef STX_ETX_XOR_FRAME_RECEIVER_DEFINES_SVH
`define STX_ETX_XOR_FRAME_RECEIVER_DEFINES_SVH

// checked only out of reset
`define STX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked during reset too
`define STX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/stx_pkg.sv @@
// Shared types and constants for the framed byte receiver.
// No dependencies; used by all RTL files of the block.
package stx_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 5;
  localparam int LEN_W  = 16;

  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'h03;

  // configuration register indexes
  localparam logic CFG_START_CODE = 1'b0;
  localparam logic CFG_END_CODE   = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_BODY  = 3'b010,
    PH_CHECK = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_GOOD = 2'd1,
    ST_ERR  = 2'd2,
    ST_OVF  = 2'd3
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  position;
    logic              in_frame;
    status_e           status;
  } res_t;

endpackage

@@ sv/stx_if.sv @@
// Valid/ready channel interfaces for the framed byte receiver.
// Depend on stx_pkg for field widths and the status type.
interface stx_rx_if;
  logic                       valid;
  logic                       ready;
  logic [stx_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stx_res_if;
  logic                       valid;
  logic                       ready;
  logic [stx_pkg::BYTE_W-1:0] data_byte;
  logic [stx_pkg::POS_W-1:0]  position;
  logic                       in_frame;
  stx_pkg::status_e           status;

  modport source (output valid, output data_byte, output position, output in_frame,
                  output status, input ready);
  modport sink   (input valid, input data_byte, input position, input in_frame,
                  input status, output ready);
endinterface

@@ sv/stx_etx_xor_frame_receiver.sv @@
// Top level of the framed byte receiver (start code / body / end code / XOR check byte).
// Depends on stx_pkg, stx_if, stx_fsm and stx_out_reg.
//
// Usage:
//   rx_i carries one received byte per beat; res_o returns exactly one result
//   beat per input beat: the byte echoed, its index in the frame, whether it
//   was stored, and a status (good frame, check/length error, overflow abort).
//   A byte accepted on rx_i is offered on res_o in the cycle after. Throughput
//   is one byte per cycle while res_o is not stalled; the frame logic is a
//   single compare/XOR pass between the input beat and the output register.
//   rx_i.ready is high while the output register is empty or being drained,
//   so a stalled res_o holds one result and back-pressures rx_i after that.
//   Reset clears the frame state to idle, empties the output register and
//   loads start_code 0x02 and end_code 0x03. cfg_we_i writes register
//   cfg_idx_i (0 start_code, 1 end_code) at any edge; write only while idle.
//   MAX_FRAME bounds the stored frame length; a longer frame aborts.
module stx_etx_xor_frame_receiver #(
  parameter int MAX_FRAME = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  stx_rx_if.sink                     rx_i,
  stx_res_if.source                  res_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [stx_pkg::BYTE_W-1:0] cfg_data_i
);

  logic [stx_pkg::BYTE_W-1:0] start_code_q;
  logic [stx_pkg::BYTE_W-1:0] end_code_q;
  logic                       accept;
  logic                       in_ready;
  stx_pkg::res_t              res_comb;
  stx_pkg::res_t              res_held;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= stx_pkg::START_CODE_RST;
      end_code_q   <= stx_pkg::END_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stx_pkg::CFG_START_CODE: start_code_q <= cfg_data_i;
        stx_pkg::CFG_END_CODE:   end_code_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rx_i.ready = in_ready;
  assign accept     = rx_i.valid && in_ready;

  stx_fsm #(
    .MAX_FRAME(MAX_FRAME)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_i.rx_byte),
    .start_code_i(start_code_q),
    .end_code_i  (end_code_q),
    .res_o       (res_comb)
  );

  stx_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_i      (res_comb),
    .out_ready_i(res_o.ready),
    .in_ready_o (in_ready),
    .out_valid_o(res_o.valid),
    .res_o      (res_held)
  );

  assign res_o.data_byte = res_held.data_byte;
  assign res_o.position  = res_held.position;
  assign res_o.in_frame  = res_held.in_frame;
  assign res_o.status    = res_held.status;

endmodule

@@ sv/stx_fsm.sv @@
// Frame state machine: phase, byte count, running XOR and length latch.
// Depends on stx_pkg and the assertion macros header.
`include "stx_etx_xor_frame_receiver_defines.svh"

module stx_fsm #(
  parameter int MAX_FRAME = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [stx_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic [stx_pkg::BYTE_W-1:0] start_code_i,
  input  logic [stx_pkg::BYTE_W-1:0] end_code_i,
  output stx_pkg::res_t              res_o
);

  localparam int CntW = $clog2(MAX_FRAME + 1);
  localparam int PosW = stx_pkg::POS_W;
  localparam int LenW = stx_pkg::LEN_W;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME);
  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntTwo = CntW'(2);

  stx_pkg::phase_e            phase_q, phase_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [stx_pkg::BYTE_W-1:0] xor_q, xor_d;
  logic [stx_pkg::BYTE_W-1:0] len_hi_q, len_hi_d;
  logic [stx_pkg::BYTE_W-1:0] len_lo_q, len_lo_d;

  logic                       stored;
  logic [PosW-1:0]            pos;
  stx_pkg::status_e           status;
  logic                       ovf;
  logic                       chk_ok;

  assign ovf    = (cnt_q >= CntMax);
  assign chk_ok = ({len_hi_q, len_lo_q} == LenW'(cnt_q)) && (xor_q == rx_byte_i);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    len_hi_d = len_hi_q;
    len_lo_d = len_lo_q;
    stored   = 1'b0;
    pos      = '0;
    status   = stx_pkg::ST_NONE;
    unique case (phase_q)
      stx_pkg::PH_BODY, stx_pkg::PH_CHECK: begin
        if (ovf) begin
          phase_d = stx_pkg::PH_IDLE;
          status  = stx_pkg::ST_OVF;
        end else if (phase_q == stx_pkg::PH_CHECK && chk_ok) begin
          stored  = 1'b1;
          pos     = PosW'(cnt_q);
          cnt_d   = cnt_q + CntOne;
          phase_d = stx_pkg::PH_IDLE;
          status  = stx_pkg::ST_GOOD;
        end else begin
          // body byte, or a failed check byte folded back into the body
          stored = 1'b1;
          pos    = PosW'(cnt_q);
          if (cnt_q == CntOne) begin
            len_hi_d = rx_byte_i;
          end else if (cnt_q == CntTwo) begin
            len_lo_d = rx_byte_i;
          end
          xor_d = xor_q ^ rx_byte_i;
          cnt_d = cnt_q + CntOne;
          if (phase_q == stx_pkg::PH_CHECK) begin
            phase_d = stx_pkg::PH_BODY;
            status  = stx_pkg::ST_ERR;
          end else if (rx_byte_i == end_code_i) begin
            phase_d = stx_pkg::PH_CHECK;
          end
        end
      end
      default: begin
        phase_d = stx_pkg::PH_IDLE;
        if (rx_byte_i == start_code_i) begin
          stored   = 1'b1;
          cnt_d    = CntOne;
          xor_d    = rx_byte_i;
          len_hi_d = '0;
          len_lo_d = '0;
          phase_d  = stx_pkg::PH_BODY;
        end
      end
    endcase
  end

  always_comb begin
    res_o.data_byte = rx_byte_i;
    res_o.position  = pos;
    res_o.in_frame  = stored;
    res_o.status    = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= stx_pkg::PH_IDLE;
      cnt_q    <= '0;
      xor_q    <= '0;
      len_hi_q <= '0;
      len_lo_q <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      xor_q    <= xor_d;
      len_hi_q <= len_hi_d;
      len_lo_q <= len_lo_d;
    end
  end

  `STX_ASSERT_ALWAYS(a_cnt_bound, rst_ni |-> cnt_q <= CntMax, "byte count past MAX_FRAME")
  `STX_ASSERT(a_cnt_in_frame, phase_q != stx_pkg::PH_IDLE |-> cnt_q != '0,
              "inside a frame with zero count")
  `STX_ASSERT(a_ovf_to_idle, accept_i && res_o.status == stx_pkg::ST_OVF
              |=> phase_q == stx_pkg::PH_IDLE, "overflow did not abort frame")
  `STX_ASSERT(a_hold_idle, !accept_i |=> $stable(cnt_q) && $stable(xor_q),
              "frame state moved without a beat")

endmodule

@@ sv/stx_out_reg.sv @@
// Output register of the framed byte receiver: holds one result beat.
// Depends on stx_pkg for the result struct.
module stx_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  stx_pkg::res_t res_i,
  input  logic          out_ready_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output stx_pkg::res_t res_o
);

  logic          valid_q, valid_d;
  stx_pkg::res_t res_q;

  // a held beat leaving this cycle frees the slot for the next one
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ tb/stx_frame_checker.sv @@
// Scoreboard for the framed byte receiver: watches the byte, result and register ports.
// Predicts one result per accepted byte and compares it field by field.
// Depends on stx_pkg and the stx_rx_if / stx_res_if interfaces.
module stx_frame_checker
  import stx_pkg::*;
#(
  parameter int MAX_FRAME = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  stx_rx_if                 rx_i,
  stx_res_if                res_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                good_frames_o,
  output int                bad_frames_o,
  output int                aborts_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = $clog2(MAX_FRAME + 2);

  // shadow copy of the frame state and the two codes
  phase_e            phase_q;
  logic [CNT_W-1:0]  count_q;
  logic [BYTE_W-1:0] xor_q;
  logic [BYTE_W-1:0] len_hi_q;
  logic [BYTE_W-1:0] len_lo_q;
  logic [BYTE_W-1:0] start_q;
  logic [BYTE_W-1:0] end_q;

  res_t expected_results[$];
  int   fail_count  = 0;
  int   good_frames = 0;
  int   bad_frames  = 0;
  int   aborts      = 0;

  assign fail_count_o  = fail_count;
  assign good_frames_o = good_frames;
  assign bad_frames_o  = bad_frames;
  assign aborts_o      = aborts;

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // append a byte to the frame: bytes 1 and 2 carry the big-endian length
  function automatic void take_byte(logic [BYTE_W-1:0] b);
    if (count_q == CNT_W'(1)) len_hi_q = b;
    else if (count_q == CNT_W'(2)) len_lo_q = b;
    xor_q   = xor_q ^ b;
    count_q = count_q + 1'b1;
  endfunction

  function automatic res_t frame_step(logic [BYTE_W-1:0] b);
    res_t r;
    r.data_byte = b;
    r.position  = '0;
    r.in_frame  = 1'b0;
    r.status    = ST_NONE;
    if (phase_q == PH_BODY || phase_q == PH_CHECK) begin
      if (int'(count_q) >= MAX_FRAME) begin
        phase_q  = PH_IDLE;
        r.status = ST_OVF;
      end else if (phase_q == PH_BODY) begin
        r.position = count_q[POS_W-1:0];
        r.in_frame = 1'b1;
        if (b == end_q) phase_q = PH_CHECK;
        take_byte(b);
      end else begin
        r.position = count_q[POS_W-1:0];
        r.in_frame = 1'b1;
        if ({len_hi_q, len_lo_q} == LEN_W'(count_q) && xor_q == b) begin
          count_q  = count_q + 1'b1;
          phase_q  = PH_IDLE;
          r.status = ST_GOOD;
        end else begin
          // bad check byte is kept as body and collection goes on
          take_byte(b);
          phase_q  = PH_BODY;
          r.status = ST_ERR;
        end
      end
    end else if (b == start_q) begin
      r.in_frame = 1'b1;
      count_q    = CNT_W'(1);
      xor_q      = b;
      len_hi_q   = '0;
      len_lo_q   = '0;
      phase_q    = PH_BODY;
    end else begin
      phase_q = PH_IDLE;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t got;
    res_t want;
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      count_q   <= '0;
      xor_q     <= '0;
      len_hi_q  <= '0;
      len_lo_q  <= '0;
      start_q   <= START_CODE_RST;
      end_q     <= END_CODE_RST;
      pending_o <= 0;
      expected_results.delete();
    end else begin
      // a result beat at this edge belongs to an earlier byte, so check first
      if (res_i.valid && res_i.ready) begin
        got.data_byte = res_i.data_byte;
        got.position  = res_i.position;
        got.in_frame  = res_i.in_frame;
        got.status    = res_i.status;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result beat %h/%0d/%0d/%s with no byte outstanding",
                                    got.data_byte, got.position, got.in_frame,
                                    got.status.name()));
        end else begin
          want = expected_results.pop_front();
          if (got.data_byte !== want.data_byte || got.position !== want.position ||
              got.in_frame !== want.in_frame || got.status !== want.status) begin
            report_mismatch($sformatf(
              "byte %h: got pos %0d frame %0d %s, want byte %h pos %0d frame %0d %s",
              got.data_byte, got.position, got.in_frame, got.status.name(),
              want.data_byte, want.position, want.in_frame, want.status.name()));
          end
        end
      end
      if (rx_i.valid && rx_i.ready) begin
        want = frame_step(rx_i.rx_byte);
        case (want.status)
          ST_GOOD: good_frames++;
          ST_ERR:  bad_frames++;
          ST_OVF:  aborts++;
          default: ;
        endcase
        expected_results.push_back(want);
      end
      // register writes take effect after this edge's byte
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_START_CODE) start_q <= cfg_data_i;
        else end_q <= cfg_data_i;
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

@@ tb/stx_etx_xor_frame_receiver_test.sv @@
// Testbench top for the framed byte receiver: drives bytes, result stalls and code writes.
// Checking is done by stx_frame_checker; depends on stx_pkg, stx_if and the RTL top.
module stx_etx_xor_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stx_pkg::*;

  localparam int MAX_FRAME   = 32;
  localparam int QUIET_LIMIT = 600;
  localparam int PHASE_BYTES = 150;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CHECK,
    FR_BAD_LEN,
    FR_NO_END,
    FR_SHORT
  } frame_kind_e;

  logic clk_i;
  logic rst_ni;
  logic              cfg_we;
  logic              cfg_idx;
  logic [BYTE_W-1:0] cfg_data;

  stx_rx_if  rx ();
  stx_res_if res ();

  int fail_count;
  int pending;
  int good_frames;
  int bad_frames;
  int aborts;

  logic [BYTE_W-1:0] cur_start = START_CODE_RST;
  logic [BYTE_W-1:0] cur_end   = END_CODE_RST;
  bit idle_on  = 1'b0;
  bit stall_on = 1'b0;
  int bytes_sent   = 0;
  int code_settings = 1;

  stx_etx_xor_frame_receiver #(.MAX_FRAME(MAX_FRAME)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  stx_frame_checker #(.MAX_FRAME(MAX_FRAME)) frame_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx),
    .res_i         (res),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .good_frames_o (good_frames),
    .bad_frames_o  (bad_frames),
    .aborts_o      (aborts)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // result side: random stall bursts while stall_on is set
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall_on && stall_left == 0 && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
        res.ready <= 1'b0;
        stall_left--;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // ends the run once nothing has moved on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni && !(rx.valid && rx.ready) && !(res.valid && res.ready)) quiet++;
      else quiet = 0;
    end
    $display("timeout: no beat for %0d cycles, %0d results outstanding", QUIET_LIMIT,
             pending);
    $display("stx_etx_xor_frame_receiver_test: FAIL");
    $finish;
  end

  // ready is sampled at the falling edge, where it is settled for the next rising edge
  task automatic send_byte(logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(negedge clk_i); while (!rx.ready);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic drain_results();
    rx.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic set_codes(logic [BYTE_W-1:0] start_code, logic [BYTE_W-1:0] end_code);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_START_CODE;
    cfg_data <= start_code;
    @(posedge clk_i);
    cfg_idx  <= CFG_END_CODE;
    cfg_data <= end_code;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_start = start_code;
    cur_end   = end_code;
    code_settings++;
  endtask

  // enough filler to run any open frame into the overflow abort and back to idle
  task automatic resync();
    logic [BYTE_W-1:0] f;
    do f = BYTE_W'($urandom); while (f == cur_start || f == cur_end);
    repeat (MAX_FRAME + 1) send_byte(f);
  endtask

  task automatic send_frame(int nbody, frame_kind_e kind);
    logic [BYTE_W-1:0] bytes_q[$];
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] stored;
    stored = BYTE_W'(nbody + 4);
    bytes_q.push_back(cur_start);
    if (kind == FR_SHORT) begin
      bytes_q.push_back(cur_end);
      bytes_q.push_back(BYTE_W'($urandom));
    end else begin
      bytes_q.push_back('0);
      bytes_q.push_back(kind == FR_BAD_LEN ? stored + BYTE_W'($urandom_range(1, 9)) : stored);
      repeat (nbody) begin
        do b = BYTE_W'($urandom); while (b == cur_end);
        bytes_q.push_back(b);
      end
      if (kind != FR_NO_END) begin
        bytes_q.push_back(cur_end);
        sum = '0;
        foreach (bytes_q[i]) sum ^= bytes_q[i];
        if (kind == FR_BAD_CHECK) sum ^= BYTE_W'($urandom_range(1, 255));
        bytes_q.push_back(sum);
      end
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i]);
    // a length byte equal to the end code cuts the frame short
    if (kind != FR_GOOD || cur_end == 8'h00 || cur_end == stored) resync();
  endtask

  // with no_gaps set the gap and stall settings are left as they are
  task automatic random_traffic(int target, bit no_gaps = 1'b0);
    int r;
    target += bytes_sent;
    while (bytes_sent < target) begin
      if (!no_gaps && $urandom_range(0, 9) == 0) begin
        idle_on  = $urandom_range(0, 2) != 0;
        stall_on = $urandom_range(0, 2) != 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
        if (r == 0) resync();
      end else if (r < 68) begin
        send_frame($urandom_range(0, 5) == 0 ? $urandom_range(9, 27) : $urandom_range(0, 8),
                   FR_GOOD);
      end else if (r < 78) begin
        send_frame($urandom_range(0, 12), FR_BAD_CHECK);
      end else if (r < 84) begin
        send_frame($urandom_range(0, 12), FR_BAD_LEN);
      end else if (r < 89) begin
        send_frame($urandom_range(0, 30), FR_NO_END);
      end else if (r < 93) begin
        send_frame(0, FR_SHORT);
      end else begin
        // longest good frame, or one whose check byte lands past the end
        send_frame($urandom_range(27, 28), FR_GOOD);
      end
    end
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] start_in_body [8];
    start_in_body = '{8'h02, 8'h00, 8'h07, 8'h02, 8'hFF, 8'h00, 8'h03, 8'hFB};
    rst_ni     = 1'b0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_START_CODE;
    cfg_data   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle noise, minimal good frame, start code in the body, too-short frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(END_CODE_RST);
    send_frame(0, FR_GOOD);
    foreach (start_in_body[i]) send_byte(start_in_body[i]);
    send_frame(0, FR_SHORT);

    idle_on  = 1'b1;
    stall_on = 1'b1;
    random_traffic(PHASE_BYTES);
    drain_results();
    random_traffic(PHASE_BYTES / 2);

    set_codes(8'h00, 8'hFF);
    random_traffic(PHASE_BYTES);
    set_codes(8'hFF, 8'h00);
    random_traffic(PHASE_BYTES);
    set_codes(BYTE_W'($urandom), BYTE_W'($urandom));
    random_traffic(PHASE_BYTES);
    set_codes(8'h7E, 8'h7E);
    random_traffic(PHASE_BYTES / 2);

    // closing stretch back on the reset codes, ending with no gaps and no stalls
    set_codes(START_CODE_RST, END_CODE_RST);
    random_traffic(PHASE_BYTES / 2);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    random_traffic(PHASE_BYTES / 2, 1'b1);

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d bytes under %0d start/end code settings with random gaps and stalls.",
             bytes_sent, code_settings);
    $display("Frames seen: %0d good, %0d check/length errors, %0d overflow aborts.",
             good_frames, bad_frames, aborts);
    if (fail_count == 0) begin
      $display("stx_etx_xor_frame_receiver_test: PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("stx_etx_xor_frame_receiver_test: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/stx_pkg.sv
sv/stx_if.sv
sv/stx_fsm.sv
sv/stx_out_reg.sv
sv/stx_etx_xor_frame_receiver.sv
tb/stx_frame_checker.sv
tb/stx_etx_xor_frame_receiver_test.sv
